@@ design/imm_pkg.sv @@
package imm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int IDX_W  = 4;

  // Reset value of both dimension registers
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Operation codes of an input item
  typedef enum logic {
    OP_LOAD_B = 1'b0,
    OP_FEED_A = 1'b1
  } imm_op_t;

  // Configuration register indexes
  typedef enum logic {
    REG_SIZE_IN_USE = 1'b0,
    REG_ROWS_IN_USE = 1'b1
  } imm_reg_t;

  // Per-cycle control broadcast to every column cell
  typedef struct packed {
    logic acc_en;     // add the registered product into the accumulator
    logic acc_first;  // first element of a row: start from zero
    logic load_res;   // row complete: copy the new sum into the result chain
    logic shift;      // result at the head taken: move the chain one cell
  } imm_cell_ctl_t;

endpackage

@@ design/imm_bank.sv @@
module imm_bank #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [imm_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [imm_pkg::DATA_W-1:0] rdata
);

  logic [imm_pkg::DATA_W-1:0] mem [DEPTH];
  logic [imm_pkg::DATA_W-1:0] rdata_r;

  // Write one element
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one element, hold it until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/imm_cell.sv @@
module imm_cell #(
  parameter int BANKS = 16,
  parameter int BW    = 4,
  parameter int COL   = 0
) (
  input  logic                                  clk,
  input  imm_pkg::imm_cell_ctl_t                ctl,
  input  logic [imm_pkg::DATA_W-1:0]            a_value,
  input  logic [BW-1:0]                         base_bank,
  input  logic [BANKS-1:0][imm_pkg::DATA_W-1:0] bank_data,
  input  logic [imm_pkg::DATA_W-1:0]            next_res,
  output logic [imm_pkg::DATA_W-1:0]            res
);

  logic [BW-1:0]              sel;
  logic [imm_pkg::DATA_W-1:0] b_value;
  logic [imm_pkg::DATA_W-1:0] prod_r;
  logic [imm_pkg::DATA_W-1:0] prod_nxt;
  logic [imm_pkg::DATA_W-1:0] acc_r;
  logic [imm_pkg::DATA_W-1:0] acc_nxt;
  logic [imm_pkg::DATA_W-1:0] res_r;

  // Pick the bank that holds this column's B element, multiply mod 2^32
  assign sel      = BW'((int'(base_bank) + COL) % BANKS);
  assign b_value  = bank_data[sel];
  assign prod_nxt = a_value * b_value;

  always_comb begin
    acc_nxt = (ctl.acc_first ? '0 : acc_r) + prod_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
    // Load the finished sum, or take the neighbor's result
    if (ctl.acc_en && ctl.load_res) begin
      res_r <= acc_nxt;
    end else if (ctl.shift) begin
      res_r <= next_res;
    end
  end

  assign res = res_r;

endmodule

@@ design/integer_matrix_multiply_top.sv @@
// Integer matrix multiply, C = A * B on signed 32-bit values, sums wrapping mod 2^32.
// Items with operation 0 load B row-major into MAX_DIM-rounded-up-to-a-power-of-two
// memory banks and items with operation 1 feed the next A element, one item per cycle
// while input is open; a row of MAX_DIM column cells multiplies each A element by a
// whole B row at once. The element that completes a row closes the input while it
// passes the read, multiply and accumulate stages, after which the n results of the
// row leave through a shift chain across the cells, one per cycle while out_ready is
// high, and input reopens once the last is taken. The B store and the accumulators
// need no clearing after reset.
module integer_matrix_multiply_top #(
  parameter int MAX_DIM = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [imm_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [imm_pkg::DATA_W-1:0] out_product_value,
  output logic [imm_pkg::IDX_W-1:0]         out_row_index,
  output logic [imm_pkg::IDX_W-1:0]         out_column_index,
  output logic                              out_last_of_row,
  output logic                              out_last_of_job,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (DW > imm_pkg::CFG_W) ? DW : imm_pkg::CFG_W;
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int LB    = $clog2(MAX_DIM);
  localparam int BANKS = 1 << LB;
  localparam int BW    = (LB > 0) ? LB : 1;
  localparam int RD    = (MAX_DIM * MAX_DIM + BANKS - 1) / BANKS;
  localparam int RW    = (RD > 1) ? $clog2(RD) : 1;

  // Clamp a dimension register into 1..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [imm_pkg::CFG_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) begin
      return DW'(1);
    end else if (w > CW'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(w);
  endfunction

  logic [imm_pkg::CFG_W-1:0] size_r;
  logic [imm_pkg::CFG_W-1:0] rows_cfg_r;
  logic [AW-1:0]             pos_r;
  logic [AW-1:0]             pos_nxt;
  logic [DW-1:0]             k_r;
  logic [DW-1:0]             k_nxt;
  logic [DW-1:0]             row_r;
  logic [DW-1:0]             row_nxt;
  logic                      pend_r;
  logic                      pend_nxt;
  logic [DW-1:0]             cnt_r;
  logic [DW-1:0]             cnt_nxt;
  logic [DW-1:0]             col_r;
  logic [DW-1:0]             col_nxt;
  logic                      s1_valid_r;
  logic                      s1_first_r;
  logic                      s1_last_r;
  logic [imm_pkg::DATA_W-1:0] s1_value_r;
  logic [BW-1:0]             s1_bank_r;
  logic                      s2_valid_r;
  logic                      s2_first_r;
  logic                      s2_last_r;
  logic [DW-1:0]             res_row_r;
  logic                      res_job_end_r;

  logic [DW-1:0]             n;
  logic [DW-1:0]             rows;
  logic [AW-1:0]             nn;
  logic                      in_fire;
  logic                      b_fire;
  logic                      a_fire;
  logic                      out_fire;
  logic [AW-1:0]             wpos;
  logic [BW-1:0]             wbank;
  logic [RW-1:0]             wrow;
  logic [DW-1:0]             kk;
  logic [AW-1:0]             base;
  logic [BW-1:0]             base_bank;
  logic [RW-1:0]             base_row;
  logic                      row_done;
  logic [DW-1:0]             rr;
  logic                      job_end;
  imm_pkg::imm_cell_ctl_t    ctl;

  logic [BANKS-1:0][imm_pkg::DATA_W-1:0]   bank_data;
  logic [MAX_DIM-1:0][imm_pkg::DATA_W-1:0] res_w;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = !pend_r && (cnt_r == '0);
  assign in_fire   = in_valid && in_ready;
  assign b_fire    = in_fire && (in_operation == imm_pkg::OP_LOAD_B);
  assign a_fire    = in_fire && (in_operation == imm_pkg::OP_FEED_A);
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  // Dimensions in use
  assign n    = clamp_dim(size_r);
  assign rows = clamp_dim(rows_cfg_r);
  assign nn   = AW'(n) * AW'(n);

  // B write address, split into bank and row
  always_comb begin
    wpos    = (pos_r >= nn) ? '0 : pos_r;
    wbank   = BW'(wpos % BANKS);
    wrow    = RW'(wpos / BANKS);
    pos_nxt = pos_r;
    if (b_fire) begin
      pos_nxt = ((wpos + AW'(1)) >= nn) ? '0 : (wpos + AW'(1));
    end
  end

  // A element position, base address of its B row, row bookkeeping
  always_comb begin
    kk        = (k_r >= n) ? '0 : k_r;
    base      = AW'(kk) * AW'(n);
    base_bank = BW'(base % BANKS);
    base_row  = RW'(base / BANKS);
    row_done  = ((kk + DW'(1)) == n);
    rr        = (row_r >= rows) ? '0 : row_r;
    job_end   = ((DW + 1)'(rr) + (DW + 1)'(1)) >= (DW + 1)'(rows);
    k_nxt     = k_r;
    row_nxt   = row_r;
    if (a_fire) begin
      k_nxt = row_done ? '0 : (kk + DW'(1));
      if (row_done) begin
        row_nxt = job_end ? '0 : (rr + DW'(1));
      end
    end
  end

  // Completion tracking and the output counters
  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    if (a_fire && row_done) begin
      pend_nxt = 1'b1;
    end
    if (s2_valid_r && s2_last_r) begin
      pend_nxt = 1'b0;
      cnt_nxt  = n;
      col_nxt  = '0;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - DW'(1);
      col_nxt = col_r + DW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= imm_pkg::CFG_RESET;
      rows_cfg_r <= imm_pkg::CFG_RESET;
      pos_r      <= '0;
      k_r        <= '0;
      row_r      <= '0;
      pend_r     <= 1'b0;
      cnt_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          imm_pkg::REG_SIZE_IN_USE: size_r     <= cfg_data;
          imm_pkg::REG_ROWS_IN_USE: rows_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      pos_r      <= pos_nxt;
      k_r        <= k_nxt;
      row_r      <= row_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= a_fire;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Stage payload and row tags
  always_ff @(posedge clk) begin
    if (a_fire) begin
      s1_first_r <= (kk == '0);
      s1_last_r  <= row_done;
      s1_value_r <= in_element_value;
      s1_bank_r  <= base_bank;
    end
    if (a_fire && row_done) begin
      res_row_r     <= rr;
      res_job_end_r <= job_end;
    end
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // Cell control
  always_comb begin
    ctl.acc_en    = s2_valid_r;
    ctl.acc_first = s2_first_r;
    ctl.load_res  = s2_last_r;
    ctl.shift     = out_fire;
  end

  // B banks: n consecutive addresses always fall in distinct banks
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [RW-1:0] raddr;
    assign raddr = base_row + ((BW'(b) < base_bank) ? RW'(1) : RW'(0));
    imm_bank #(
      .DEPTH (RD),
      .AW    (RW)
    ) u_bank (
      .clk   (clk),
      .we    (b_fire && (wbank == BW'(b))),
      .waddr (wrow),
      .wdata (in_element_value),
      .re    (a_fire),
      .raddr (raddr),
      .rdata (bank_data[b])
    );
  end

  // Column cells, results shift toward column 0
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic [imm_pkg::DATA_W-1:0] next_res;
    if (j == MAX_DIM - 1) begin : g_tail
      assign next_res = '0;
    end else begin : g_link
      assign next_res = res_w[j + 1];
    end
    imm_cell #(
      .BANKS (BANKS),
      .BW    (BW),
      .COL   (j)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .a_value   (s1_value_r),
      .base_bank (s1_bank_r),
      .bank_data (bank_data),
      .next_res  (next_res),
      .res       (res_w[j])
    );
  end

  // Result fields
  assign out_product_value = res_w[0];
  assign out_row_index     = imm_pkg::IDX_W'(res_row_r);
  assign out_column_index  = imm_pkg::IDX_W'(col_r);
  assign out_last_of_row   = (cnt_r == DW'(1));
  assign out_last_of_job   = (cnt_r == DW'(1)) && res_job_end_r;

  // A row loads the chain only when it is empty
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_last_r) |-> (cnt_r == '0))
    else $error("result chain loaded while not empty");

  // A row in flight always has its completion pending
  a_pend_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ((s1_valid_r && s1_last_r) || (s2_valid_r && s2_last_r)) |-> pend_r)
    else $error("row completion in flight without pending flag");

  // The final result of a row empties the chain
  a_row_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_of_row) |=> !out_valid)
    else $error("results remain after the last of a row");

  // Never more results queued than columns
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n)
    else $error("result count exceeds row length");

endmodule

@@ tb/tb_integer_matrix_multiply_top.sv @@
`timescale 1ns / 100ps
module tb_integer_matrix_multiply_top;

  localparam int DATA_W        = imm_pkg::DATA_W;
  localparam int CFG_W         = imm_pkg::CFG_W;
  localparam int IDX_W         = imm_pkg::IDX_W;
  localparam int MAX_DIM       = 16;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 80;

  typedef struct {
    imm_pkg::imm_op_t  op;
    logic [DATA_W-1:0] value;
  } matrix_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last_row;
    logic                     last_job;
  } c_element_t;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic                     in_operation     = 1'b0;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic signed [DATA_W-1:0] out_product_value;
  logic [IDX_W-1:0]         out_row_index;
  logic [IDX_W-1:0]         out_column_index;
  logic                     out_last_of_row;
  logic                     out_last_of_job;
  logic                     cfg_valid        = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_index        = 1'b0;
  logic [CFG_W-1:0]         cfg_data         = '0;

  // Shadow of the block: B store, column sums, counters and dimension registers
  logic [DATA_W-1:0] b_matrix [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] col_sum [MAX_DIM];
  logic [8:0]        b_load_pos = '0;
  logic [4:0]        a_pos      = '0;
  logic [4:0]        row_cnt    = '0;
  logic [CFG_W-1:0]  size_reg   = imm_pkg::CFG_RESET;
  logic [CFG_W-1:0]  rows_reg   = imm_pkg::CFG_RESET;

  c_element_t   c_expected [$];
  matrix_item_t pending_items [$];

  int  in_taken_cnt  = 0;
  int  out_taken_cnt = 0;
  int  fail_cnt      = 0;
  int  cycle_cnt     = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  int  queued_cnt    = 0;
  int  loaded_n      = 0;

  integer_matrix_multiply_top #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_product_value(out_product_value),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_last_of_row  (out_last_of_row),
    .out_last_of_job  (out_last_of_job),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Advance the shadow by one item; a completed A row queues one C element per column
  function automatic void predict_c_row(imm_pkg::imm_op_t op, logic [DATA_W-1:0] v);
    int n;
    int rows;
    int pos;
    int k;
    int row;
    logic [DATA_W-1:0] base;
    logic job_end;
    c_element_t e;
    n    = clamp_dim(size_reg);
    rows = clamp_dim(rows_reg);
    if (op == imm_pkg::OP_LOAD_B) begin
      pos = b_load_pos;
      if (pos >= n * n) pos = 0;
      b_matrix[pos] = v;
      pos++;
      if (pos >= n * n) pos = 0;
      b_load_pos = 9'(pos);
      return;
    end
    k = a_pos;
    if (k >= n) k = 0;
    for (int j = 0; j < n; j++) begin
      base = (k == 0) ? '0 : col_sum[j];
      col_sum[j] = base + v * b_matrix[k * n + j];
    end
    k++;
    if (k < n) begin
      a_pos = 5'(k);
      return;
    end
    a_pos = '0;
    row = row_cnt;
    if (row >= rows) row = 0;
    job_end = (row + 1 >= rows);
    for (int j = 0; j < n; j++) begin
      e.value    = col_sum[j];
      e.row      = IDX_W'(row);
      e.col      = IDX_W'(j);
      e.last_row = (j == n - 1);
      e.last_job = (j == n - 1) && job_end;
      c_expected.push_back(e);
    end
    row_cnt = job_end ? 5'd0 : 5'(row + 1);
  endfunction

  // Track config writes, predict on accepted items, check accepted results
  always @(posedge clk) begin
    c_element_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == imm_pkg::REG_SIZE_IN_USE) size_reg = cfg_data;
        else rows_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_c_row(imm_pkg::imm_op_t'(in_operation), in_element_value);
        in_taken_cnt <= in_taken_cnt + 1;
      end
      if (out_valid && out_ready) begin
        out_taken_cnt <= out_taken_cnt + 1;
        if (c_expected.size() == 0) begin
          $error("unexpected result: row %0d column %0d value %0d",
                 out_row_index, out_column_index, out_product_value);
          fail_cnt++;
        end else begin
          want = c_expected.pop_front();
          if (out_product_value !== want.value) begin
            $error("product_value: expected %0d, actual %0d", want.value, out_product_value);
            fail_cnt++;
          end
          if (out_row_index !== want.row) begin
            $error("row_index: expected %0d, actual %0d", want.row, out_row_index);
            fail_cnt++;
          end
          if (out_column_index !== want.col) begin
            $error("column_index: expected %0d, actual %0d", want.col, out_column_index);
            fail_cnt++;
          end
          if (out_last_of_row !== want.last_row) begin
            $error("last_of_row: expected %0d, actual %0d", want.last_row, out_last_of_row);
            fail_cnt++;
          end
          if (out_last_of_job !== want.last_job) begin
            $error("last_of_job: expected %0d, actual %0d", want.last_job, out_last_of_job);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Offer the next pending item, idling at random outside the calm window
  always @(posedge clk) begin
    matrix_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 &&
          ((in_taken_cnt >= 45 && in_taken_cnt < 85) || $urandom_range(99) >= 28)) begin
        nxt = pending_items.pop_front();
        in_valid         <= 1'b1;
        in_operation     <= nxt.op;
        in_element_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive out_ready: one long hold while results wait, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_valid && in_valid && in_taken_cnt >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (out_taken_cnt >= 15 && out_taken_cnt < 45) || ($urandom_range(99) >= 28);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      4:       return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_item(imm_pkg::imm_op_t op, logic [DATA_W-1:0] v);
    matrix_item_t it;
    it.op    = op;
    it.value = v;
    pending_items.push_back(it);
    queued_cnt++;
  endfunction

  function automatic void load_b(int count);
    for (int i = 0; i < count; i++) push_item(imm_pkg::OP_LOAD_B, pick_element());
  endfunction

  // Queue A elements, now and then slipping a B load in between
  function automatic void feed_a(int count, bit mix);
    for (int i = 0; i < count; i++) begin
      if (mix && $urandom_range(9) == 0) push_item(imm_pkg::OP_LOAD_B, pick_element());
      push_item(imm_pkg::OP_FEED_A, pick_element());
    end
  endfunction

  // Wait until all items are taken and all results are in, let the pipe drain, recheck
  task automatic settle();
    do begin
      while (pending_items.size() != 0 || in_valid || c_expected.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || c_expected.size() != 0 ||
               out_valid);
  endtask

  task automatic write_reg(imm_pkg::imm_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Write both dimensions while idle; reload B when asked and the dimension in use changes
  task automatic set_dims(logic [CFG_W-1:0] size_val, logic [CFG_W-1:0] rows_val, bit reload);
    int n;
    settle();
    n = clamp_dim(size_val);
    if ($urandom_range(1)) begin
      write_reg(imm_pkg::REG_SIZE_IN_USE, size_val);
      write_reg(imm_pkg::REG_ROWS_IN_USE, rows_val);
    end else begin
      write_reg(imm_pkg::REG_ROWS_IN_USE, rows_val);
      write_reg(imm_pkg::REG_SIZE_IN_USE, size_val);
    end
    if (reload && n != loaded_n) load_b(n * n);
    loaded_n = n;
  endtask

  initial begin
    int n;
    int r;
    logic [CFG_W-1:0] size_val;
    logic [CFG_W-1:0] rows_val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2: extreme B values, one extra load to wrap, B rewrite in mid-row
    set_dims(5'd2, 5'd2, 1'b0);
    push_item(imm_pkg::OP_LOAD_B, 32'h7fff_ffff);
    push_item(imm_pkg::OP_LOAD_B, 32'h8000_0000);
    push_item(imm_pkg::OP_LOAD_B, 32'hffff_ffff);
    push_item(imm_pkg::OP_LOAD_B, 32'h0000_0001);
    push_item(imm_pkg::OP_LOAD_B, 32'h0000_0005);
    push_item(imm_pkg::OP_FEED_A, 32'h8000_0000);
    push_item(imm_pkg::OP_FEED_A, 32'h7fff_ffff);
    push_item(imm_pkg::OP_FEED_A, 32'hffff_ffff);
    push_item(imm_pkg::OP_LOAD_B, 32'h0000_0003);
    push_item(imm_pkg::OP_LOAD_B, 32'hffff_fff9);
    push_item(imm_pkg::OP_FEED_A, 32'h0000_0000);
    // leave a row half done
    push_item(imm_pkg::OP_FEED_A, 32'h0000_0001);

    // size 0 acts as 1, rows 31 as 16; the half row restarts, load position restarts
    set_dims(5'd0, 5'd31, 1'b0);
    push_item(imm_pkg::OP_LOAD_B, 32'h7fff_ffff);
    push_item(imm_pkg::OP_FEED_A, 32'h8000_0000);
    push_item(imm_pkg::OP_FEED_A, 32'hffff_ffff);
    push_item(imm_pkg::OP_FEED_A, 32'h0000_0002);

    // fewer rows than the counter holds: next row is row 0
    set_dims(5'd3, 5'd2, 1'b1);
    feed_a(6, 1'b0);

    // random phases, mostly small sizes
    queued_cnt = 0;
    while (queued_cnt < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 10) size_val = 5'd0;
      else if (r < 65) size_val = 5'($urandom_range(1, 4));
      else size_val = 5'($urandom_range(5, 6));
      rows_val = ($urandom_range(99) < 30) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 4));
      set_dims(size_val, rows_val, 1'b1);
      n = clamp_dim(size_val);
      if ($urandom_range(99) < 30) load_b($urandom_range(1, n * n));
      for (int i = $urandom_range(1, 4); i > 0; i--) feed_a(n, 1'b1);
      // broken row at the end of the phase
      if (n > 1 && $urandom_range(99) < 25) feed_a($urandom_range(1, n - 1), 1'b1);
    end

    // drain and report
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/imm_pkg.sv
design/imm_bank.sv
design/imm_cell.sv
design/integer_matrix_multiply_top.sv
tb/tb_integer_matrix_multiply_top.sv
